>>> src/tlv_type_range_span_scanner_top_macros.svh
// Assertion macros used by the scanner parser (tlvs_parser).
`ifndef TLV_TYPE_RANGE_SPAN_SCANNER_TOP_MACROS_SVH
`define TLV_TYPE_RANGE_SPAN_SCANNER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TLVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TLVS_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);
`else
`define TLVS_ASSERT(lbl, prop, msg)
`define TLVS_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif

`endif

>>> src/tlvs_pkg.sv
`timescale 1ns / 1ps

package tlvs_pkg;

  localparam int MAX_STREAM_BYTES = 65536;
  localparam int POS_W            = $clog2(MAX_STREAM_BYTES + 1);
  localparam int OUT_W            = 17;
  localparam int TYPE_W           = 64;
  localparam int BYTE_W           = 8;
  localparam int CFG_IDX_W        = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_TYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TYPE = 1'd1;

  localparam logic [1:0] PH_TYPE  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  localparam logic [BYTE_W-1:0] BS_PFX_2 = 8'hfd;
  localparam logic [BYTE_W-1:0] BS_PFX_4 = 8'hfe;

  typedef struct packed {
    logic [TYPE_W-1:0] min_type;
    logic [TYPE_W-1:0] max_type;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] stream_byte;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] span_start;
    logic [OUT_W-1:0] span_length;
    logic             malformed;
  } result_t;

endpackage

>>> src/tlvs_ifs.sv
`timescale 1ns / 1ps

interface tlvs_in_if;
  import tlvs_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              is_last;

  modport source (output valid, output stream_byte, output is_last, input ready);
  modport sink (input valid, input stream_byte, input is_last, output ready);
endinterface

interface tlvs_out_if;
  import tlvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] span_start;
  logic [OUT_W-1:0] span_length;
  logic             malformed;

  modport source (output valid, output span_start, output span_length, output malformed,
                  input ready);
  modport sink (input valid, input span_start, input span_length, input malformed,
                output ready);
endinterface

>>> src/tlv_type_range_span_scanner_top.sv
`timescale 1ns / 1ps
// A result is shown once the byte marked last has passed the input register and the result register.
// Throughput: one stream byte per cycle; the parse state is updated in a single step.
// Only a last byte waits for the result register, and only while a result is still held.
// Reset: rst_n is synchronous and active low; it clears the parse state and the result
// valid flag, and sets min_type to zero and max_type to all ones.

module tlv_type_range_span_scanner_top (
  input  logic                           clk,
  input  logic                           rst_n,
  tlvs_in_if.sink                        in_ch,
  tlvs_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [tlvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlvs_pkg::TYPE_W-1:0]    cfg_wdata
);
  import tlvs_pkg::*;

  cfg_t     cfg;
  result_t  res;
  in_item_t item_r, item_nxt;
  logic     in_valid_r, in_valid_nxt;
  logic     out_free;
  logic     step;

  assign step        = in_valid_r && (!item_r.is_last || out_free);
  assign in_ch.ready = !in_valid_r || step;

  always_comb begin
    in_valid_nxt = in_valid_r;
    item_nxt     = item_r;
    if (step) begin
      in_valid_nxt = 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_valid_nxt         = 1'b1;
      item_nxt.stream_byte = in_ch.stream_byte;
      item_nxt.is_last     = in_ch.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
    item_r <= item_nxt;
  end

  tlvs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tlvs_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (step),
    .item  (item_r),
    .res   (res)
  );

  tlvs_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

>>> src/tlvs_cfg_regs.sv
`timescale 1ns / 1ps

module tlvs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tlvs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tlvs_pkg::TYPE_W-1:0]      cfg_wdata,
  output tlvs_pkg::cfg_t                   cfg
);
  import tlvs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_TYPE: cfg_nxt.min_type = cfg_wdata;
        REG_MAX_TYPE: cfg_nxt.max_type = cfg_wdata;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_type <= '0;
      cfg_r.max_type <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> src/tlvs_parser.sv
`timescale 1ns / 1ps
`include "tlv_type_range_span_scanner_top_macros.svh"

module tlvs_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  tlvs_pkg::cfg_t     cfg,
  input  logic               step,
  input  tlvs_pkg::in_item_t item,
  output tlvs_pkg::result_t  res
);
  import tlvs_pkg::*;

  logic [1:0]        phase_r, phase_nxt;
  logic [3:0]        bleft_r, bleft_nxt;
  logic [BYTE_W-1:0] prefix_r, prefix_nxt;
  logic [TYPE_W-1:0] acc_r, acc_nxt;
  logic [TYPE_W-1:0] rtype_r, rtype_nxt;
  logic [TYPE_W-1:0] vleft_r, vleft_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  rbegin_r, rbegin_nxt;
  logic [POS_W-1:0]  sbegin_r, sbegin_nxt;
  logic              found_r, found_nxt;
  logic [POS_W-1:0]  send_r, send_nxt;
  logic              end_ok_r, end_ok_nxt;
  logic              stop_r, stop_nxt;
  logic              err_r, err_nxt;

  logic              fdone;
  logic [TYPE_W-1:0] fval;
  logic              below_floor;
  logic              bad;
  logic [POS_W-1:0]  pos_inc;

  assign pos_inc = pos_r + POS_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    bleft_nxt   = bleft_r;
    prefix_nxt  = prefix_r;
    acc_nxt     = acc_r;
    rtype_nxt   = rtype_r;
    vleft_nxt   = vleft_r;
    pos_nxt     = pos_r;
    rbegin_nxt  = rbegin_r;
    sbegin_nxt  = sbegin_r;
    found_nxt   = found_r;
    send_nxt    = send_r;
    end_ok_nxt  = end_ok_r;
    stop_nxt    = stop_r;
    err_nxt     = err_r;
    fdone       = 1'b0;
    fval        = '0;
    below_floor = 1'b0;
    bad         = 1'b0;
    res         = '0;

    if (step && !err_r && !stop_r) begin
      if (pos_r >= POS_W'(MAX_STREAM_BYTES)) begin
        err_nxt = 1'b1;
      end else begin
        pos_nxt = pos_inc;
        if (phase_r == PH_VALUE) begin
          vleft_nxt = vleft_r - TYPE_W'(1);
          if (vleft_r == TYPE_W'(1)) begin
            send_nxt   = pos_inc;
            end_ok_nxt = 1'b1;
            phase_nxt  = PH_TYPE;
          end
        end else if (bleft_r == 4'd0) begin
          if (phase_r == PH_TYPE) begin
            rbegin_nxt = pos_r;
          end
          prefix_nxt = item.stream_byte;
          acc_nxt    = '0;
          if (item.stream_byte < BS_PFX_2) begin
            fdone = 1'b1;
            fval  = TYPE_W'(item.stream_byte);
          end else if (item.stream_byte == BS_PFX_2) begin
            bleft_nxt = 4'd2;
          end else if (item.stream_byte == BS_PFX_4) begin
            bleft_nxt = 4'd4;
          end else begin
            bleft_nxt = 4'd8;
          end
        end else begin
          acc_nxt   = {acc_r[TYPE_W-BYTE_W-1:0], item.stream_byte};
          bleft_nxt = bleft_r - 4'd1;
          if (bleft_r == 4'd1) begin
            if (prefix_r == BS_PFX_2) begin
              below_floor = (acc_nxt[15:0] < 16'h00fd);
            end else if (prefix_r == BS_PFX_4) begin
              below_floor = (acc_nxt[31:16] == 16'h0000);
            end else begin
              below_floor = (acc_nxt[63:32] == 32'h0000_0000);
            end
            if (below_floor) begin
              err_nxt = 1'b1;
            end else begin
              fdone = 1'b1;
              fval  = acc_nxt;
            end
          end
        end

        if (fdone) begin
          if (phase_r == PH_TYPE) begin
            rtype_nxt = fval;
            phase_nxt = PH_LEN;
          end else begin
            if ((rtype_r >= cfg.min_type) && !found_r) begin
              sbegin_nxt = rbegin_r;
              found_nxt  = 1'b1;
            end
            if (rtype_r > cfg.max_type) begin
              stop_nxt = 1'b1;
            end else begin
              vleft_nxt = fval;
              if (fval == '0) begin
                send_nxt   = pos_inc;
                end_ok_nxt = 1'b1;
                phase_nxt  = PH_TYPE;
              end else begin
                phase_nxt = PH_VALUE;
              end
            end
          end
        end
      end
    end

    if (step && item.is_last) begin
      bad = err_nxt || (!stop_nxt && ((phase_nxt != PH_TYPE) || (bleft_nxt != 4'd0)));
      res.valid     = 1'b1;
      res.malformed = bad;
      if (!bad) begin
        if (found_nxt) begin
          res.span_start = OUT_W'(sbegin_nxt);
          if (end_ok_nxt && (send_nxt >= sbegin_nxt)) begin
            res.span_length = OUT_W'(send_nxt - sbegin_nxt);
          end
        end else if (end_ok_nxt) begin
          res.span_start = OUT_W'(send_nxt);
        end
      end
      phase_nxt  = PH_TYPE;
      bleft_nxt  = '0;
      prefix_nxt = '0;
      acc_nxt    = '0;
      rtype_nxt  = '0;
      vleft_nxt  = '0;
      pos_nxt    = '0;
      rbegin_nxt = '0;
      sbegin_nxt = '0;
      found_nxt  = 1'b0;
      send_nxt   = '0;
      end_ok_nxt = 1'b0;
      stop_nxt   = 1'b0;
      err_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      bleft_r  <= '0;
      prefix_r <= '0;
      acc_r    <= '0;
      rtype_r  <= '0;
      vleft_r  <= '0;
      pos_r    <= '0;
      rbegin_r <= '0;
      sbegin_r <= '0;
      found_r  <= 1'b0;
      send_r   <= '0;
      end_ok_r <= 1'b0;
      stop_r   <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      bleft_r  <= bleft_nxt;
      prefix_r <= prefix_nxt;
      acc_r    <= acc_nxt;
      rtype_r  <= rtype_nxt;
      vleft_r  <= vleft_nxt;
      pos_r    <= pos_nxt;
      rbegin_r <= rbegin_nxt;
      sbegin_r <= sbegin_nxt;
      found_r  <= found_nxt;
      send_r   <= send_nxt;
      end_ok_r <= end_ok_nxt;
      stop_r   <= stop_nxt;
      err_r    <= err_nxt;
    end
  end

  `TLVS_ASSERT(a_err_stop_excl, !(err_r && stop_r), "error and stop flags both set")
  `TLVS_ASSERT(a_pos_bound, pos_r <= POS_W'(MAX_STREAM_BYTES), "byte position out of range")
  `TLVS_ASSERT_NEXT(a_clear_on_last, step && item.is_last, (pos_r == '0) && !err_r && !found_r, "stream state not cleared after the last byte")
  `TLVS_ASSERT_NEXT(a_err_sticky, err_r && !(step && item.is_last), err_r, "error flag dropped inside a stream")

endmodule

>>> src/tlvs_out_reg.sv
`timescale 1ns / 1ps

module tlvs_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  tlvs_pkg::result_t res,
  output logic              out_free,
  tlvs_out_if.source        out_ch
);
  import tlvs_pkg::*;

  logic             valid_r, valid_nxt;
  logic [OUT_W-1:0] start_r, start_nxt;
  logic [OUT_W-1:0] length_r, length_nxt;
  logic             mal_r, mal_nxt;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt  = valid_r;
    start_nxt  = start_r;
    length_nxt = length_r;
    mal_nxt    = mal_r;
    if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
    if (res.valid) begin
      valid_nxt  = 1'b1;
      start_nxt  = res.span_start;
      length_nxt = res.span_length;
      mal_nxt    = res.malformed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    start_r  <= start_nxt;
    length_r <= length_nxt;
    mal_r    <= mal_nxt;
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.span_start  = start_r;
  assign out_ch.span_length = length_r;
  assign out_ch.malformed   = mal_r;

endmodule

>>> tb/tlv_type_range_span_scanner_top_tb.sv
`timescale 1ns / 1ps

module tlv_type_range_span_scanner_top_tb;
  import tlvs_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES_PER_PHASE = 262;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam logic [TYPE_W-1:0] ALL_ONES = '1;
  localparam logic [BYTE_W-1:0] BS_PFX_8 = 8'hff;

  typedef struct packed {
    logic [OUT_W-1:0] span_start;
    logic [OUT_W-1:0] span_length;
    logic             malformed;
  } span_report_t;

  typedef enum {WELL_FORMED, TRUNCATED, NON_MINIMAL, NOISE} stream_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TYPE_W-1:0]    cfg_wdata;

  tlvs_in_if in_ch ();
  tlvs_out_if out_ch ();

  tlv_type_range_span_scanner_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [TYPE_W-1:0] lo_type;
  logic [TYPE_W-1:0] hi_type;
  logic [1:0]        phase;
  int unsigned       bs_left;
  logic [7:0]        bs_prefix;
  logic [63:0]       bs_acc;
  logic [63:0]       cur_type;
  logic [63:0]       value_left;
  logic [OUT_W-1:0]  pos;
  logic [OUT_W-1:0]  rec_begin;
  logic [OUT_W-1:0]  sel_begin;
  logic [OUT_W-1:0]  sel_end;
  bit                sel_begin_found;
  bit                sel_end_valid;
  bit                stopped;
  bit                broken;

  span_report_t expected_spans[$];
  logic [7:0]   stream_bytes[$];
  int           errors = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           hold_request = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_scan();
    phase = PH_TYPE;
    bs_left = 0;
    bs_prefix = '0;
    bs_acc = '0;
    cur_type = '0;
    value_left = '0;
    pos = '0;
    rec_begin = '0;
    sel_begin = '0;
    sel_begin_found = 1'b0;
    sel_end = '0;
    sel_end_valid = 1'b0;
    stopped = 1'b0;
    broken = 1'b0;
  endfunction

  function automatic void close_field(logic [63:0] v);
    if (phase == PH_TYPE) begin
      cur_type = v;
      phase = PH_LEN;
      return;
    end
    if (cur_type >= lo_type && !sel_begin_found) begin
      sel_begin = rec_begin;
      sel_begin_found = 1'b1;
    end
    if (cur_type > hi_type) begin
      stopped = 1'b1;
      return;
    end
    value_left = v;
    if (v == 0) begin
      sel_end = pos + 1'b1;
      sel_end_valid = 1'b1;
      phase = PH_TYPE;
    end else begin
      phase = PH_VALUE;
    end
  endfunction

  function automatic void track_scan_byte(logic [7:0] b, bit last);
    logic [63:0]  floor_v;
    span_report_t r;
    bit           bad;
    if (!broken && !stopped) begin
      if (pos >= MAX_STREAM_BYTES) begin
        broken = 1'b1;
      end else begin
        if (phase == PH_VALUE) begin
          value_left--;
          if (value_left == 0) begin
            sel_end = pos + 1'b1;
            sel_end_valid = 1'b1;
            phase = PH_TYPE;
          end
        end else if (bs_left == 0) begin
          if (phase == PH_TYPE) rec_begin = pos;
          bs_prefix = b;
          bs_acc = '0;
          if (b < BS_PFX_2) close_field(64'(b));
          else bs_left = (b == BS_PFX_2) ? 2 : (b == BS_PFX_4) ? 4 : 8;
        end else begin
          bs_acc = {bs_acc[55:0], b};
          bs_left--;
          if (bs_left == 0) begin
            floor_v = (bs_prefix == BS_PFX_2) ? 64'hfd :
                      (bs_prefix == BS_PFX_4) ? 64'h1_0000 : 64'h1_0000_0000;
            if (bs_acc < floor_v) broken = 1'b1;
            else close_field(bs_acc);
          end
        end
        pos++;
      end
    end
    if (last) begin
      bad = broken || (!stopped && (phase != PH_TYPE || bs_left != 0));
      r = '0;
      r.malformed = bad;
      if (!bad) begin
        if (sel_begin_found) begin
          r.span_start = sel_begin;
          if (sel_end_valid && sel_end >= sel_begin) r.span_length = sel_end - sel_begin;
        end else if (sel_end_valid) begin
          r.span_start = sel_end;
        end
      end
      expected_spans.push_back(r);
      clear_scan();
    end
  endfunction

  function automatic int minimal_width(logic [63:0] v);
    if (v < 64'hfd) return 1;
    if (v <= 64'hffff) return 2;
    if (v <= 64'hffff_ffff) return 4;
    return 8;
  endfunction

  function automatic void push_encoded(logic [63:0] v, int n);
    if (n == 1) begin
      stream_bytes.push_back(v[7:0]);
    end else begin
      stream_bytes.push_back(n == 2 ? BS_PFX_2 : n == 4 ? BS_PFX_4 : BS_PFX_8);
      for (int i = n - 1; i >= 0; i--) stream_bytes.push_back(v[8*i +: 8]);
    end
  endfunction

  function automatic logic [63:0] pick_type();
    case ($urandom_range(7))
      0: return lo_type;
      1: return hi_type;
      2: return lo_type - 1;
      3: return hi_type + 1;
      4: return 64'($urandom_range(0, 20));
      5: return {$urandom, $urandom};
      6: return 64'($urandom_range(0, 300));
      default: begin
        case ($urandom_range(5))
          0: return 64'hfc;
          1: return 64'hfd;
          2: return 64'hffff;
          3: return 64'h1_0000;
          4: return 64'hffff_ffff;
          default: return 64'h1_0000_0000;
        endcase
      end
    endcase
  endfunction

  function automatic void add_record(logic [63:0] t, logic [63:0] len, int bad_field);
    int          wide;
    logic [63:0] len_v;
    wide = 2 << $urandom_range(0, 2);
    len_v = len;
    if (bad_field == 1) push_encoded(64'($urandom_range(0, 'hfc)), wide);
    else push_encoded(t, minimal_width(t));
    if (bad_field == 2) begin
      len_v = 64'($urandom_range(0, 4));
      push_encoded(len_v, wide);
    end else begin
      push_encoded(len_v, minimal_width(len_v));
    end
    for (longint unsigned k = 0; k < len_v; k++) stream_bytes.push_back(8'($urandom));
  endfunction

  function automatic stream_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 70) return WELL_FORMED;
    if (r < 80) return TRUNCATED;
    if (r < 90) return NON_MINIMAL;
    return NOISE;
  endfunction

  function automatic void build_stream(stream_kind_t kind);
    int          nrec;
    int          bad_rec;
    int          cut;
    logic [63:0] len;
    stream_bytes.delete();
    if (kind == NOISE) begin
      repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom));
      return;
    end
    nrec = $urandom_range(1, 5);
    bad_rec = (kind == NON_MINIMAL) ? $urandom_range(0, nrec - 1) : -1;
    for (int i = 0; i < nrec; i++) begin
      len = ($urandom_range(15) == 0) ? 64'($urandom_range(250, 260))
                                      : 64'($urandom_range(0, 4));
      add_record(pick_type(), len, (i == bad_rec) ? $urandom_range(1, 2) : 0);
    end
    if (kind == TRUNCATED && stream_bytes.size() > 1) begin
      cut = $urandom_range(1, stream_bytes.size() - 1);
      stream_bytes = stream_bytes[0:cut-1];
    end
  endfunction

  task automatic send_byte(logic [7:0] b, bit last);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.stream_byte <= b;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    track_scan_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_stream();
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_spans.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TYPE_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_MIN_TYPE) lo_type = data;
    else hi_type = data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_types(logic [TYPE_W-1:0] lo, logic [TYPE_W-1:0] hi);
    drain();
    write_reg(REG_MIN_TYPE, lo);
    write_reg(REG_MAX_TYPE, hi);
  endtask

  task automatic test_directed();
    set_types(64'd2, 64'h10);
    idle_pct = 0;
    stall_pct = 0;
    stream_bytes = '{8'h01, 8'h00, 8'h02, 8'h01, 8'hff};
    send_stream();
    stream_bytes = '{8'hfd, 8'h00, 8'hfc, 8'h00};
    send_stream();
    stream_bytes = '{8'h03, 8'hfe, 8'h00, 8'h00, 8'hff, 8'hff};
    send_stream();
    stream_bytes = '{8'h11, 8'h00, 8'hfe};
    send_stream();
    stream_bytes = '{8'h01, 8'h00};
    send_stream();
    stream_bytes = '{8'h01, 8'h02, 8'haa};
    send_stream();
    stream_bytes = '{8'hfe};
    send_stream();
  endtask

  task automatic test_back_pressure();
    drain();
    idle_pct = 0;
    stall_pct = 0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (12) begin
      stream_bytes = '{8'($urandom_range(0, 'hfc)), 8'h00};
      send_stream();
    end
  endtask

  task automatic test_random_phase(int src_idle, int snk_stall, logic [TYPE_W-1:0] lo,
                                   logic [TYPE_W-1:0] hi);
    int sent = 0;
    set_types(lo, hi);
    idle_pct = src_idle;
    stall_pct = snk_stall;
    while (sent < RANDOM_BYTES_PER_PHASE) begin
      build_stream(pick_kind());
      sent += stream_bytes.size();
      send_stream();
    end
  endtask

  // A long hold-off keeps one result parked so that the next last byte cannot transfer.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    span_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_spans.size() == 0) begin
        $error("result transfer with no expected span: start %0d length %0d malformed %0d",
               out_ch.span_start, out_ch.span_length, out_ch.malformed);
        errors++;
      end else begin
        want = expected_spans.pop_front();
        if (out_ch.span_start !== want.span_start) begin
          $error("span_start: expected %0d, got %0d", want.span_start, out_ch.span_start);
          errors++;
        end
        if (out_ch.span_length !== want.span_length) begin
          $error("span_length: expected %0d, got %0d", want.span_length, out_ch.span_length);
          errors++;
        end
        if (out_ch.malformed !== want.malformed) begin
          $error("malformed: expected %0d, got %0d", want.malformed, out_ch.malformed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int lo_pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MIN_TYPE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.stream_byte = '0;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
    clear_scan();
    lo_type = '0;
    hi_type = ALL_ONES;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_back_pressure();
    test_random_phase(0, 0, 64'h10, 64'h40);
    test_random_phase(84, 0, ALL_ONES, ALL_ONES);
    test_random_phase(0, 84, '0, '0);
    lo_pick = $urandom_range(0, 8);
    test_random_phase(22, 22, 64'(lo_pick), 64'(lo_pick + $urandom_range(0, 300)));
    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
